### rtl/core/fsc_pkg.sv
// ----------------------------------------------------------------------------
// fsc_pkg: shared types and constants for the frustum sphere cull block
// Field widths, default fraction width, and the control/status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package fsc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int ELEM_W   = 32;
  localparam int COORD_W  = 32;
  localparam int RADIUS_W = 31;
  localparam int IDX_W    = 2;
  localparam int PLANE_W  = 3;

  localparam int NUM_PLANES = 6;
  localparam int SQRT_STEPS = 32;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TEST  = 1'b1;

  localparam logic [PLANE_W-1:0] LAST_PLANE = 3'd5;
  localparam logic [PLANE_W-1:0] ALL_PASSED = 3'd6;

  // one input item
  typedef struct packed {
    logic                       operation;
    logic [IDX_W-1:0]           row_index;
    logic [IDX_W-1:0]           col_index;
    logic signed [ELEM_W-1:0]   element_value;
    logic signed [COORD_W-1:0]  center_x;
    logic signed [COORD_W-1:0]  center_y;
    logic signed [COORD_W-1:0]  center_z;
    logic [RADIUS_W-1:0]        sphere_radius;
  } fsc_item_t;

  // controller to datapath
  typedef struct packed {
    logic               mat_wr;
    logic               latch_test;
    logic               ld_r3;
    logic               ld_p;
    logic               mul_sq;
    logic               mul_dot;
    logic               acc_clr;
    logic               acc_add;
    logic               sqrt_init;
    logic               sqrt_step;
    logic               plane_zero;
    logic               div_init;
    logic               div_step;
    logic               plane_wr;
    logic [PLANE_W-1:0] plane;
    logic [IDX_W-1:0]   comp;
  } fsc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic len_zero;
    logic cull;
    logic keep;
  } fsc_stat_t;

endpackage

### rtl/core/frustum_sphere_cull.sv
// ----------------------------------------------------------------------------
// frustum_sphere_cull: sphere versus view frustum visibility test
// Matrix writes are taken while idle. A sphere test walks the planes in turn on the
// shared multiply-accumulate and stops at the first plane that decides the result.
// After any matrix write the next test first rebuilds six planes, each by reads,
// squares, square root, a check and, for a nonzero length, a division; the
// one-bit-per-cycle divider dominates.
// Reset (synchronous, rst high): identity matrix, planes marked for rebuild, no result.
// ----------------------------------------------------------------------------
module frustum_sphere_cull #(
  parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // row_index[1:0], col_index[3:2], element_value[35:4], center_x[67:36],
  // center_y[99:68], center_z[131:100], sphere_radius[162:132], zero fill
  input  logic [167:0] s_tdata,
  // operation
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // visible[0], deciding_plane[3:1], zero fill
  output logic [7:0]   m_tdata
);
  import fsc_pkg::*;

  fsc_item_t          item;
  fsc_cmd_t           cmd;
  fsc_stat_t          stat;
  logic               out_visible;
  logic [PLANE_W-1:0] out_plane;

  // unpack the slave-side transfer
  assign item.operation     = s_tuser;
  assign item.row_index     = s_tdata[1:0];
  assign item.col_index     = s_tdata[3:2];
  assign item.element_value = s_tdata[35:4];
  assign item.center_x      = s_tdata[67:36];
  assign item.center_y      = s_tdata[99:68];
  assign item.center_z      = s_tdata[131:100];
  assign item.sphere_radius = s_tdata[162:132];

  fsc_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_op       (s_tuser),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_visible (out_visible),
    .out_plane   (out_plane),
    .cmd         (cmd),
    .stat        (stat)
  );

  fsc_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .cmd  (cmd),
    .stat (stat)
  );

  // pack the master-side transfer
  assign m_tdata = {4'b0000, out_plane, out_visible};

endmodule

### rtl/core/fsc_dp.sv
// ----------------------------------------------------------------------------
// fsc_dp: datapath of the frustum sphere cull block
// Matrix and plane registers, shared multiplier and accumulator, one-step-per-
// cycle square root and one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
module fsc_dp #(
  parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  fsc_pkg::fsc_item_t item,
  input  fsc_pkg::fsc_cmd_t  cmd,
  output fsc_pkg::fsc_stat_t stat
);
  import fsc_pkg::*;

  localparam int NW = 34 + FRAC_BITS;

  logic signed [ELEM_W-1:0]   mat [4][4];
  logic signed [ELEM_W-1:0]   planes [NUM_PLANES][4];
  logic signed [ELEM_W-1:0]   r3;
  logic signed [32:0]         p [4];
  logic signed [COORD_W-1:0]  cx, cy, cz;
  logic [RADIUS_W-1:0]        rad;
  logic signed [63:0]         prod;
  logic signed [63:0]         acc;
  logic [63:0]                sv, sr, sb;
  logic [32:0]                rem;
  logic [NW-1:0]              num, quo;

  logic [32:0]        mag [4];
  logic               shift1;
  logic [32:0]        den;
  logic [IDX_W-1:0]   rd_row;
  logic signed [ELEM_W-1:0] rd_elem;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_full;
  logic signed [ELEM_W-1:0] p_elem;
  logic signed [32:0] coord;
  logic [63:0]        trial;
  logic [33:0]        rem_sh;
  logic [NW-1:0]      lim, q_sat;
  logic [31:0]        q32;
  logic signed [63:0] rr, absd;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      mag[j] = p[j][32] ? 33'(-p[j]) : 33'(p[j]);
    end
  end

  assign shift1 = mag[0][32] | mag[0][31] | mag[1][32] | mag[1][31] | mag[2][32] | mag[2][31];
  assign den    = shift1 ? {sr[31:0], 1'b0} : {1'b0, sr[31:0]};

  // one matrix read port: row 3 first, then row k
  assign rd_row  = cmd.ld_r3 ? 2'd3 : cmd.plane[2:1];
  assign rd_elem = mat[rd_row][cmd.comp];

  assign p_elem = planes[cmd.plane][cmd.comp];

  always_comb begin
    case (cmd.comp)
      2'd0:    coord = 33'(cx);
      2'd1:    coord = 33'(cy);
      2'd2:    coord = 33'(cz);
      default: coord = 33'sd1 <<< FRAC_BITS;
    endcase
  end

  always_comb begin
    if (cmd.mul_sq) begin
      mul_a = shift1 ? $signed({1'b0, mag[cmd.comp][32:1]}) : $signed(mag[cmd.comp]);
      mul_b = mul_a;
    end else begin
      mul_a = 33'(p_elem);
      mul_b = coord;
    end
  end

  assign mul_full = mul_a * mul_b;
  assign trial    = sr + sb;
  assign rem_sh   = {rem, num[NW-1]};

  always_comb begin
    if (cmd.comp != 2'd3) begin
      lim = NW'(1) << FRAC_BITS;
    end else if (p[3][32]) begin
      lim = NW'(32'h8000_0000);
    end else begin
      lim = NW'(32'h7FFF_FFFF);
    end
    q_sat = (quo > lim) ? lim : quo;
    q32   = q_sat[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          mat[r][c] <= (r == c) ? ELEM_W'(1) << FRAC_BITS : '0;
        end
      end
    end else if (cmd.mat_wr) begin
      mat[item.row_index][item.col_index] <= item.element_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_test) begin
      cx  <= item.center_x;
      cy  <= item.center_y;
      cz  <= item.center_z;
      rad <= item.sphere_radius;
    end
    if (cmd.ld_r3) begin
      r3 <= rd_elem;
    end
    if (cmd.ld_p) begin
      p[cmd.comp] <= cmd.plane[0] ? 33'(r3) - 33'(rd_elem) : 33'(r3) + 33'(rd_elem);
    end
    if (cmd.mul_sq || cmd.mul_dot) begin
      prod <= mul_full[63:0];
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + prod;
    end
    if (cmd.sqrt_init) begin
      sv <= acc;
      sr <= '0;
      sb <= 64'h4000_0000_0000_0000;
    end else if (cmd.sqrt_step) begin
      if (sv >= trial) begin
        sv <= sv - trial;
        sr <= (sr >> 1) + sb;
      end else begin
        sr <= sr >> 1;
      end
      sb <= sb >> 2;
    end
    if (cmd.div_init) begin
      num <= (NW'(mag[cmd.comp]) << FRAC_BITS) + NW'(den[32:1]);
      rem <= '0;
      quo <= '0;
    end else if (cmd.div_step) begin
      num <= num << 1;
      if (rem_sh >= {1'b0, den}) begin
        rem <= 33'(rem_sh - {1'b0, den});
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[32:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
    if (cmd.plane_zero) begin
      for (int c = 0; c < 4; c++) begin
        planes[cmd.plane][c] <= '0;
      end
    end else if (cmd.plane_wr) begin
      planes[cmd.plane][cmd.comp] <= p[cmd.comp][32] ? $signed(-q32) : $signed(q32);
    end
  end

  assign rr   = $signed(64'(rad) << FRAC_BITS);
  assign absd = acc[63] ? -acc : acc;

  assign stat.len_zero = (sr[31:0] == 32'd0);
  assign stat.cull     = acc < -rr;
  assign stat.keep     = absd < rr;

endmodule

### rtl/core/fsc_ctrl.sv
// ----------------------------------------------------------------------------
// fsc_ctrl: sequencer of the frustum sphere cull block
// Takes items, rebuilds the planes after matrix writes, walks the planes for
// a test and holds the result register.
// ----------------------------------------------------------------------------
module fsc_ctrl #(
  parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_op,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_visible,
  output logic [fsc_pkg::PLANE_W-1:0]  out_plane,
  output fsc_pkg::fsc_cmd_t            cmd,
  input  fsc_pkg::fsc_stat_t           stat
);
  import fsc_pkg::*;

  localparam int NW    = 34 + FRAC_BITS;
  localparam int CNT_W = $clog2(NW);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD3  = 4'd1;
  localparam logic [3:0] S_RDK  = 4'd2;
  localparam logic [3:0] S_SQ   = 4'd3;
  localparam logic [3:0] S_SQRT = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_DIVI = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_DIVW = 4'd8;
  localparam logic [3:0] S_MAC  = 4'd9;
  localparam logic [3:0] S_CMP  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0]         state;
  logic [PLANE_W-1:0] plane;
  logic [IDX_W-1:0]   comp;
  logic [CNT_W-1:0]   cnt;
  logic               stale;
  logic               res_vis;
  logic [PLANE_W-1:0] res_plane;
  logic               out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd            = '0;
    cmd.plane      = plane;
    cmd.comp       = comp;
    cmd.mat_wr     = in_valid && in_ready && (in_op == OP_WRITE);
    cmd.latch_test = in_valid && in_ready && (in_op == OP_TEST);
    case (state)
      S_RD3:  cmd.ld_r3 = 1'b1;
      S_RDK:  cmd.ld_p  = 1'b1;
      S_SQ: begin
        cmd.comp    = cnt[IDX_W-1:0];
        cmd.mul_sq  = (cnt != CNT_W'(3));
        cmd.acc_clr = (cnt == '0);
        cmd.acc_add = (cnt != '0);
      end
      S_SQRT: begin
        cmd.sqrt_init = (cnt == '0);
        cmd.sqrt_step = (cnt != '0);
      end
      S_CHK:  cmd.plane_zero = stat.len_zero;
      S_DIVI: cmd.div_init   = 1'b1;
      S_DIV:  cmd.div_step   = 1'b1;
      S_DIVW: cmd.plane_wr   = 1'b1;
      S_MAC: begin
        cmd.comp    = cnt[IDX_W-1:0];
        cmd.mul_dot = (cnt != CNT_W'(4));
        cmd.acc_clr = (cnt == '0);
        cmd.acc_add = (cnt != '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      plane     <= '0;
      comp      <= '0;
      cnt       <= '0;
      stale     <= 1'b1;   // planes of the reset matrix are built at the first test
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_op == OP_WRITE) begin
              stale <= 1'b1;
            end else begin
              plane <= '0;
              comp  <= '0;
              cnt   <= '0;
              state <= stale ? S_RD3 : S_MAC;
            end
          end
        end
        S_RD3: state <= S_RDK;
        S_RDK: begin
          if (comp == 2'd3) begin
            comp  <= '0;
            cnt   <= '0;
            state <= S_SQ;
          end else begin
            comp  <= comp + 2'd1;
            state <= S_RD3;
          end
        end
        S_SQ: begin
          if (cnt == CNT_W'(3)) begin
            cnt   <= '0;
            state <= S_SQRT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SQRT: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(SQRT_STEPS)) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          comp <= '0;
          if (!stat.len_zero) begin
            state <= S_DIVI;
          end else if (plane == LAST_PLANE) begin
            stale <= 1'b0;
            plane <= '0;
            cnt   <= '0;
            state <= S_MAC;
          end else begin
            plane <= plane + 1'b1;
            state <= S_RD3;
          end
        end
        S_DIVI: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(NW - 1)) begin
            state <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (comp != 2'd3) begin
            comp  <= comp + 2'd1;
            state <= S_DIVI;
          end else if (plane == LAST_PLANE) begin
            comp  <= '0;
            stale <= 1'b0;
            plane <= '0;
            cnt   <= '0;
            state <= S_MAC;
          end else begin
            comp  <= '0;
            plane <= plane + 1'b1;
            state <= S_RD3;
          end
        end
        S_MAC: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(4)) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          cnt <= '0;
          if (stat.cull) begin
            res_vis   <= 1'b0;
            res_plane <= plane;
            state     <= S_OUT;
          end else if (stat.keep) begin
            res_vis   <= 1'b1;
            res_plane <= plane;
            state     <= S_OUT;
          end else if (plane == LAST_PLANE) begin
            res_vis   <= 1'b1;
            res_plane <= ALL_PASSED;
            state     <= S_OUT;
          end else begin
            plane <= plane + 1'b1;
            state <= S_MAC;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result payload: load as the result register takes it
  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_visible <= res_vis;
      out_plane   <= res_plane;
    end
  end

  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> (out_valid && state == S_IDLE))
    else $error("result not loaded on leaving output state");

  a_stale_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(stale) |-> (state == S_MAC && plane == '0 && cnt == '0))
    else $error("planes marked fresh outside end of rebuild");

  a_plane_range: assert property (@(posedge clk) disable iff (rst)
    plane <= LAST_PLANE)
    else $error("plane index out of range");

  a_out_plane: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_plane <= ALL_PASSED && (out_visible || out_plane != ALL_PASSED)))
    else $error("bad result code");

endmodule
